@@ design/ffsa_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and types of the first-fit sub-allocator.
package ffsa_pkg;

   localparam int BLOCK_ENTRIES = 64;
   localparam int FRAME_SLOTS   = 3;

   localparam int IDX_W   = $clog2(BLOCK_ENTRIES);
   localparam int LINK_W  = $clog2(BLOCK_ENTRIES + 1);
   localparam int FRAME_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

   localparam logic [LINK_W-1:0]  NIL_LINK   = LINK_W'(BLOCK_ENTRIES);
   localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAME_SLOTS - 1);

   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_FRAME = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_NO_FIT  = 2'd1;
   localparam logic [1:0] STAT_UNKNOWN = 2'd2;
   localparam logic [1:0] STAT_NOT_USE = 2'd3;

   localparam logic [1:0] REG_POOL_SIZE  = 2'd0;
   localparam logic [1:0] REG_MIN_ALIGN  = 2'd1;
   localparam logic [1:0] REG_MIN_BLOCK  = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_DISPATCH, S_START, S_APOW, S_WRD, S_WEV, S_CPOW, S_SPLIT,
      S_SPW1, S_SPW2, S_SPW3, S_FRD, S_FEV, S_QRD, S_QEV, S_QINS, S_QLNK,
      S_BTOP, S_BT, S_BPRD, S_BP, S_BPW2, S_BNCHK, S_BN, S_BNW2, S_DONE
   } state_type;

endpackage

@@ design/ffsa_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module ffsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ design/first_fit_suballocator_deferred_free_top.sv @@
`timescale 1ns / 1ps
// Top level of the first-fit sub-allocator with deferred free and coalescing.
//
//  Channel | Direction | Handshake            | Payload
//  req_    | in        | req_tvalid/req_tready | tuser: mode; tdata: size, alignment, handle
//  rsp_    | out       | rsp_tvalid/rsp_tready | tdata: status, granted handle, granted offset
//  csr_    | in        | csr_valid/csr_ready   | csr_index, csr_wdata
//
// Each item is handled alone by one sequencer around one table read port.
// Allocate finds the alignment power, walks the table entries, rounds the need up
// to a power of two, then does its split writes. Free walks the entries to find
// the handle, then passes the queued entries of the frame to find its place.
// Begin frame releases each queued block of the new frame, merging free neighbours.
// Reset is synchronous and clears all flags and list heads at once; there is no
// clearing pass. The finished result sits in an output register, so a stalled
// result channel holds back only the next result, not the next transfer in.
module first_fit_suballocator_deferred_free_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // mode
   input  logic [95:0] req_tdata,   // request_size, request_alignment, block_handle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // status, granted_handle, granted_offset, zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int N  = ffsa_pkg::BLOCK_ENTRIES;
   localparam int LW = ffsa_pkg::LINK_W;
   localparam int IW = ffsa_pkg::IDX_W;

   ffsa_pkg::state_type state_ff, state_in;

   logic [1:0]  mode_ff, mode_in;
   logic [31:0] size_ff, size_in, ralign_ff, ralign_in, handle_ff, handle_in;
   logic [31:0] pool_ff, pool_in, minblk_ff, minblk_in;
   logic [16:0] minal_ff, minal_in;

   logic [N-1:0] listed_ff, listed_in, inuse_ff, inuse_in, freeing_ff, freeing_in;
   logic [LW-1:0] head_ff, head_in;
   logic [LW-1:0] fq_ff [ffsa_pkg::FRAME_SLOTS];
   logic [LW-1:0] fq_in [ffsa_pkg::FRAME_SLOTS];
   logic [ffsa_pkg::FRAME_W-1:0] frame_ff, frame_in;
   logic [31:0] nextid_ff, nextid_in;
   logic        started_ff, started_in;

   logic [LW-1:0] cur_ff, cur_in, steps_ff, steps_in, w_ff, w_in, pv_ff, pv_in;
   logic [LW-1:0] p_ff, p_in, cafter_ff, cafter_in, tbefore_ff, tbefore_in;
   logic [LW-1:0] spare_ff, spare_in;
   logic [33:0] pow_ff, pow_in;
   logic [31:0] align_ff, align_in, coff_ff, coff_in, csize_ff, csize_in;
   logic [32:0] need_ff, need_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] ghandle_ff, ghandle_in, goff_ff, goff_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_handle_ff, rsp_handle_in, rsp_off_ff, rsp_off_in;

   // Table port: one shared read address, one shared write address.
   logic [IW-1:0] rd_addr, wr_addr;
   logic we_off, we_size, we_ident, we_after, we_before, we_qlink;
   logic [31:0] wd_off, wd_size, wd_ident, rd_off, rd_size, rd_ident;
   logic [LW-1:0] wd_after, wd_before, wd_qlink, rd_after, rd_before, rd_qlink;

   logic [31:0] max_align, align_mask, pad_c, sp_rem;
   logic [32:0] need_c;

   ffsa_ram #(.WIDTH(32), .DEPTH(N)) u_off_ram (.clock, .wr_en(we_off), .wr_addr,
      .wr_data(wd_off), .rd_addr, .rd_data(rd_off));
   ffsa_ram #(.WIDTH(32), .DEPTH(N)) u_size_ram (.clock, .wr_en(we_size), .wr_addr,
      .wr_data(wd_size), .rd_addr, .rd_data(rd_size));
   ffsa_ram #(.WIDTH(32), .DEPTH(N)) u_ident_ram (.clock, .wr_en(we_ident), .wr_addr,
      .wr_data(wd_ident), .rd_addr, .rd_data(rd_ident));
   ffsa_ram #(.WIDTH(LW), .DEPTH(N)) u_after_ram (.clock, .wr_en(we_after), .wr_addr,
      .wr_data(wd_after), .rd_addr, .rd_data(rd_after));
   ffsa_ram #(.WIDTH(LW), .DEPTH(N)) u_before_ram (.clock, .wr_en(we_before), .wr_addr,
      .wr_data(wd_before), .rd_addr, .rd_data(rd_before));
   ffsa_ram #(.WIDTH(LW), .DEPTH(N)) u_qlink_ram (.clock, .wr_en(we_qlink), .wr_addr,
      .wr_data(wd_qlink), .rd_addr, .rd_data(rd_qlink));

   // The lowest unlisted entry, computed from the listed flags and registered.
   always_comb begin
      spare_in = ffsa_pkg::NIL_LINK;
      for (int i = N - 1; i >= 0; i--) begin
         if (!listed_ff[i]) spare_in = LW'(i);
      end
   end

   assign max_align  = (ralign_ff > {15'd0, minal_ff}) ? ralign_ff : {15'd0, minal_ff};
   assign align_mask = align_ff - 32'd1;
   // Padding up to the next aligned offset is the negated offset under the mask.
   assign pad_c      = (32'd0 - rd_off) & align_mask;
   assign need_c     = {1'b0, size_ff} + {1'b0, pad_c};
   assign sp_rem     = csize_ff - pow_ff[31:0];

   assign req_tready = (state_ff == ffsa_pkg::S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_off_ff, rsp_handle_ff, rsp_status_ff};

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff; size_in = size_ff; ralign_in = ralign_ff; handle_in = handle_ff;
      pool_in = pool_ff; minal_in = minal_ff; minblk_in = minblk_ff;
      listed_in = listed_ff; inuse_in = inuse_ff; freeing_in = freeing_ff;
      head_in = head_ff; fq_in = fq_ff; frame_in = frame_ff;
      nextid_in = nextid_ff; started_in = started_ff;
      cur_in = cur_ff; steps_in = steps_ff; w_in = w_ff; pv_in = pv_ff; p_in = p_ff;
      cafter_in = cafter_ff; tbefore_in = tbefore_ff; pow_in = pow_ff;
      align_in = align_ff; coff_in = coff_ff; csize_in = csize_ff; need_in = need_ff;
      status_in = status_ff; ghandle_in = ghandle_ff; goff_in = goff_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff; rsp_handle_in = rsp_handle_ff; rsp_off_in = rsp_off_ff;
      rd_addr = '0; wr_addr = '0;
      we_off = 1'b0; we_size = 1'b0; we_ident = 1'b0;
      we_after = 1'b0; we_before = 1'b0; we_qlink = 1'b0;
      wd_off = '0; wd_size = '0; wd_ident = '0;
      wd_after = ffsa_pkg::NIL_LINK; wd_before = ffsa_pkg::NIL_LINK;
      wd_qlink = ffsa_pkg::NIL_LINK;

      if (csr_valid) begin
         case (csr_index)
            ffsa_pkg::REG_POOL_SIZE: pool_in = csr_wdata;
            ffsa_pkg::REG_MIN_ALIGN: minal_in = csr_wdata[16:0];
            ffsa_pkg::REG_MIN_BLOCK: minblk_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ffsa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               size_in = req_tdata[31:0];
               ralign_in = req_tdata[63:32];
               handle_in = req_tdata[95:64];
               state_in = ffsa_pkg::S_DISPATCH;
            end
         end
         ffsa_pkg::S_DISPATCH: begin
            status_in = ffsa_pkg::STAT_OK;
            ghandle_in = '0;
            goff_in = '0;
            pow_in = 34'd1;
            cur_in = head_ff;
            steps_in = '0;
            case (mode_ff)
               ffsa_pkg::MODE_ALLOC:
                  state_in = started_ff ? ffsa_pkg::S_APOW : ffsa_pkg::S_START;
               ffsa_pkg::MODE_FREE: state_in = ffsa_pkg::S_FRD;
               ffsa_pkg::MODE_FRAME: begin
                  frame_in = (frame_ff == ffsa_pkg::LAST_FRAME) ? '0 : frame_ff + 1'b1;
                  state_in = ffsa_pkg::S_BTOP;
               end
               default: state_in = ffsa_pkg::S_DONE;
            endcase
         end
         ffsa_pkg::S_START: begin
            if (spare_ff == ffsa_pkg::NIL_LINK) begin
               status_in = ffsa_pkg::STAT_NO_FIT;
               state_in = ffsa_pkg::S_DONE;
            end else begin
               wr_addr = spare_ff[IW-1:0];
               we_off = 1'b1; we_size = 1'b1; we_ident = 1'b1;
               we_after = 1'b1; we_before = 1'b1; we_qlink = 1'b1;
               wd_size = pool_ff;
               wd_ident = nextid_ff;
               listed_in[spare_ff[IW-1:0]] = 1'b1;
               inuse_in[spare_ff[IW-1:0]] = 1'b0;
               freeing_in[spare_ff[IW-1:0]] = 1'b0;
               nextid_in = nextid_ff + 32'd1;
               head_in = spare_ff;
               started_in = 1'b1;
               state_in = ffsa_pkg::S_APOW;
            end
         end
         ffsa_pkg::S_APOW: begin
            // Highest power of two not above the combined alignment.
            if ((pow_ff << 1) <= {2'd0, max_align}) begin
               pow_in = pow_ff << 1;
            end else begin
               align_in = pow_ff[31:0];
               cur_in = head_ff;
               steps_in = '0;
               state_in = ffsa_pkg::S_WRD;
            end
         end
         ffsa_pkg::S_WRD: begin
            if (cur_ff == ffsa_pkg::NIL_LINK || steps_ff == LW'(N)) begin
               status_in = ffsa_pkg::STAT_NO_FIT;
               state_in = ffsa_pkg::S_DONE;
            end else begin
               rd_addr = cur_ff[IW-1:0];
               state_in = ffsa_pkg::S_WEV;
            end
         end
         ffsa_pkg::S_WEV: begin
            if (!inuse_ff[cur_ff[IW-1:0]] && {1'b0, rd_size} >= need_c) begin
               inuse_in[cur_ff[IW-1:0]] = 1'b1;
               ghandle_in = rd_ident;
               goff_in = rd_off + pad_c;
               coff_in = rd_off;
               csize_in = rd_size;
               cafter_in = rd_after;
               need_in = need_c;
               pow_in = 34'd1;
               state_in = ffsa_pkg::S_CPOW;
            end else begin
               cur_in = rd_after;
               steps_in = steps_ff + 1'b1;
               state_in = ffsa_pkg::S_WRD;
            end
         end
         ffsa_pkg::S_CPOW: begin
            if (pow_ff < {1'b0, need_ff}) pow_in = pow_ff << 1;
            else state_in = ffsa_pkg::S_SPLIT;
         end
         ffsa_pkg::S_SPLIT: begin
            if ({2'd0, csize_ff} <= pow_ff || sp_rem < minblk_ff ||
                spare_ff == ffsa_pkg::NIL_LINK) begin
               state_in = ffsa_pkg::S_DONE;
            end else begin
               state_in = ffsa_pkg::S_SPW1;
            end
         end
         ffsa_pkg::S_SPW1: begin
            wr_addr = spare_ff[IW-1:0];
            we_off = 1'b1; we_size = 1'b1; we_ident = 1'b1;
            we_after = 1'b1; we_before = 1'b1; we_qlink = 1'b1;
            wd_off = coff_ff + pow_ff[31:0];
            wd_size = sp_rem;
            wd_ident = nextid_ff;
            wd_after = cafter_ff;
            wd_before = cur_ff;
            listed_in[spare_ff[IW-1:0]] = 1'b1;
            inuse_in[spare_ff[IW-1:0]] = 1'b0;
            freeing_in[spare_ff[IW-1:0]] = 1'b0;
            nextid_in = nextid_ff + 32'd1;
            p_in = spare_ff;
            state_in = ffsa_pkg::S_SPW2;
         end
         ffsa_pkg::S_SPW2: begin
            if (cafter_ff != ffsa_pkg::NIL_LINK) begin
               wr_addr = cafter_ff[IW-1:0];
               we_before = 1'b1;
               wd_before = p_ff;
            end
            state_in = ffsa_pkg::S_SPW3;
         end
         ffsa_pkg::S_SPW3: begin
            wr_addr = cur_ff[IW-1:0];
            we_after = 1'b1;
            wd_after = p_ff;
            we_size = 1'b1;
            wd_size = pow_ff[31:0];
            state_in = ffsa_pkg::S_DONE;
         end
         ffsa_pkg::S_FRD: begin
            if (!started_ff || cur_ff == ffsa_pkg::NIL_LINK || steps_ff == LW'(N)) begin
               status_in = ffsa_pkg::STAT_UNKNOWN;
               state_in = ffsa_pkg::S_DONE;
            end else begin
               rd_addr = cur_ff[IW-1:0];
               state_in = ffsa_pkg::S_FEV;
            end
         end
         ffsa_pkg::S_FEV: begin
            if (rd_ident == handle_ff) begin
               if (!inuse_ff[cur_ff[IW-1:0]] || freeing_ff[cur_ff[IW-1:0]]) begin
                  status_in = ffsa_pkg::STAT_NOT_USE;
                  state_in = ffsa_pkg::S_DONE;
               end else begin
                  freeing_in[cur_ff[IW-1:0]] = 1'b1;
                  coff_in = rd_off;
                  w_in = fq_ff[frame_ff];
                  pv_in = ffsa_pkg::NIL_LINK;
                  steps_in = '0;
                  state_in = ffsa_pkg::S_QRD;
               end
            end else begin
               cur_in = rd_after;
               steps_in = steps_ff + 1'b1;
               state_in = ffsa_pkg::S_FRD;
            end
         end
         ffsa_pkg::S_QRD: begin
            if (w_ff == ffsa_pkg::NIL_LINK || steps_ff == LW'(N)) begin
               state_in = ffsa_pkg::S_QINS;
            end else begin
               rd_addr = w_ff[IW-1:0];
               state_in = ffsa_pkg::S_QEV;
            end
         end
         ffsa_pkg::S_QEV: begin
            if (rd_off >= coff_ff) begin
               state_in = ffsa_pkg::S_QINS;
            end else begin
               pv_in = w_ff;
               w_in = rd_qlink;
               steps_in = steps_ff + 1'b1;
               state_in = ffsa_pkg::S_QRD;
            end
         end
         ffsa_pkg::S_QINS: begin
            wr_addr = cur_ff[IW-1:0];
            we_qlink = 1'b1;
            wd_qlink = w_ff;
            if (pv_ff == ffsa_pkg::NIL_LINK) begin
               fq_in[frame_ff] = cur_ff;
               state_in = ffsa_pkg::S_DONE;
            end else begin
               state_in = ffsa_pkg::S_QLNK;
            end
         end
         ffsa_pkg::S_QLNK: begin
            wr_addr = pv_ff[IW-1:0];
            we_qlink = 1'b1;
            wd_qlink = cur_ff;
            state_in = ffsa_pkg::S_DONE;
         end
         ffsa_pkg::S_BTOP: begin
            if (steps_ff == LW'(N) || fq_ff[frame_ff] == ffsa_pkg::NIL_LINK) begin
               state_in = ffsa_pkg::S_DONE;
            end else begin
               cur_in = fq_ff[frame_ff];
               rd_addr = fq_ff[frame_ff][IW-1:0];
               state_in = ffsa_pkg::S_BT;
            end
         end
         ffsa_pkg::S_BT: begin
            fq_in[frame_ff] = rd_qlink;
            wr_addr = cur_ff[IW-1:0];
            we_qlink = 1'b1;
            csize_in = rd_size;
            coff_in = rd_off;
            p_in = rd_before;
            cafter_in = rd_after;
            tbefore_in = rd_before;
            if (rd_before != ffsa_pkg::NIL_LINK && !inuse_ff[rd_before[IW-1:0]])
               state_in = ffsa_pkg::S_BPRD;
            else
               state_in = ffsa_pkg::S_BNCHK;
         end
         ffsa_pkg::S_BPRD: begin
            rd_addr = p_ff[IW-1:0];
            state_in = ffsa_pkg::S_BP;
         end
         ffsa_pkg::S_BP: begin
            // The free block before absorbs into this one, then leaves the list.
            csize_in = csize_ff + rd_size;
            coff_in = rd_off;
            tbefore_in = rd_before;
            wr_addr = cur_ff[IW-1:0];
            we_size = 1'b1; wd_size = csize_ff + rd_size;
            we_off = 1'b1; wd_off = rd_off;
            we_before = 1'b1; wd_before = rd_before;
            listed_in[p_ff[IW-1:0]] = 1'b0;
            inuse_in[p_ff[IW-1:0]] = 1'b0;
            freeing_in[p_ff[IW-1:0]] = 1'b0;
            if (rd_before == ffsa_pkg::NIL_LINK) begin
               head_in = cur_ff;
               state_in = ffsa_pkg::S_BNCHK;
            end else begin
               state_in = ffsa_pkg::S_BPW2;
            end
         end
         ffsa_pkg::S_BPW2: begin
            wr_addr = tbefore_ff[IW-1:0];
            we_after = 1'b1;
            wd_after = cur_ff;
            state_in = ffsa_pkg::S_BNCHK;
         end
         ffsa_pkg::S_BNCHK: begin
            if (cafter_ff != ffsa_pkg::NIL_LINK && !inuse_ff[cafter_ff[IW-1:0]]) begin
               rd_addr = cafter_ff[IW-1:0];
               state_in = ffsa_pkg::S_BN;
            end else begin
               inuse_in[cur_ff[IW-1:0]] = 1'b0;
               freeing_in[cur_ff[IW-1:0]] = 1'b0;
               steps_in = steps_ff + 1'b1;
               state_in = ffsa_pkg::S_BTOP;
            end
         end
         ffsa_pkg::S_BN: begin
            // This block merges into the free block after it and leaves the list.
            wr_addr = cafter_ff[IW-1:0];
            we_size = 1'b1; wd_size = rd_size + csize_ff;
            we_off = 1'b1; wd_off = coff_ff;
            we_before = 1'b1; wd_before = tbefore_ff;
            listed_in[cur_ff[IW-1:0]] = 1'b0;
            inuse_in[cur_ff[IW-1:0]] = 1'b0;
            freeing_in[cur_ff[IW-1:0]] = 1'b0;
            if (tbefore_ff == ffsa_pkg::NIL_LINK) begin
               head_in = cafter_ff;
               steps_in = steps_ff + 1'b1;
               state_in = ffsa_pkg::S_BTOP;
            end else begin
               state_in = ffsa_pkg::S_BNW2;
            end
         end
         ffsa_pkg::S_BNW2: begin
            wr_addr = tbefore_ff[IW-1:0];
            we_after = 1'b1;
            wd_after = cafter_ff;
            steps_in = steps_ff + 1'b1;
            state_in = ffsa_pkg::S_BTOP;
         end
         ffsa_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = status_ff;
               rsp_handle_in = (status_ff == ffsa_pkg::STAT_OK) ? ghandle_ff : '0;
               rsp_off_in = (status_ff == ffsa_pkg::STAT_OK) ? goff_ff : '0;
               state_in = ffsa_pkg::S_IDLE;
            end
         end
         default: state_in = ffsa_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffsa_pkg::S_IDLE;
         pool_ff <= 32'd268435456;
         minal_ff <= 17'd1;
         minblk_ff <= 32'd64;
         listed_ff <= '0;
         inuse_ff <= '0;
         freeing_ff <= '0;
         head_ff <= ffsa_pkg::NIL_LINK;
         for (int i = 0; i < ffsa_pkg::FRAME_SLOTS; i++) fq_ff[i] <= ffsa_pkg::NIL_LINK;
         frame_ff <= '0;
         nextid_ff <= '0;
         started_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pool_ff <= pool_in;
         minal_ff <= minal_in;
         minblk_ff <= minblk_in;
         listed_ff <= listed_in;
         inuse_ff <= inuse_in;
         freeing_ff <= freeing_in;
         head_ff <= head_in;
         fq_ff <= fq_in;
         frame_ff <= frame_in;
         nextid_ff <= nextid_in;
         started_ff <= started_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in; size_ff <= size_in; ralign_ff <= ralign_in;
      handle_ff <= handle_in;
      cur_ff <= cur_in; steps_ff <= steps_in; w_ff <= w_in; pv_ff <= pv_in; p_ff <= p_in;
      cafter_ff <= cafter_in; tbefore_ff <= tbefore_in; spare_ff <= spare_in;
      pow_ff <= pow_in; align_ff <= align_in; coff_ff <= coff_in; csize_ff <= csize_in;
      need_ff <= need_in; status_ff <= status_in; ghandle_ff <= ghandle_in;
      goff_ff <= goff_in;
      rsp_status_ff <= rsp_status_in; rsp_handle_ff <= rsp_handle_in;
      rsp_off_ff <= rsp_off_in;
   end
endmodule

@@ design/ffsa_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the sub-allocator top, with its bind statement.
module ffsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   // A result waiting on the output holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed while stalled");

   // One item at a time: after a transfer in, the input is closed.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open right after a transfer");

   // Every failure carries zero handle and offset.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ffsa_pkg::STAT_OK |-> rsp_tdata[65:2] == 64'd0)
      else $error("failed result with nonzero grant");

   // Fill bits above the fields stay zero.
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[71:66] == 6'd0)
      else $error("fill bits set");
endmodule

bind first_fit_suballocator_deferred_free_top ffsa_checker u_ffsa_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

@@ verif/tb_first_fit_suballocator_deferred_free_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the first-fit sub-allocator with deferred free.
module tb_first_fit_suballocator_deferred_free_top;
   import ffsa_pkg::*;

   localparam int NIL          = BLOCK_ENTRIES;
   localparam int SETTLE       = 700;     // worst begin-frame walk plus margin
   localparam int STALL_LIMIT  = 20000;   // cycles with no transfer at all
   localparam int HOLD_CYCLES  = 400;     // long back-pressure burst on the result side

   // One expected or observed grant.
   typedef struct {
      logic [1:0]  status;
      logic [31:0] handle;
      logic [31:0] offset;
   } grant_type;

   // Scoreboard: a private copy of the block table and frame ring, advanced on
   // every request transfer, plus the queue of grants still to be seen.
   class alloc_scoreboard_type;
      bit [31:0]   pool_bytes, min_split;
      bit [16:0]   min_align;
      bit [31:0]   blk_off[BLOCK_ENTRIES], blk_len[BLOCK_ENTRIES], blk_id[BLOCK_ENTRIES];
      bit          listed[BLOCK_ENTRIES], used[BLOCK_ENTRIES], freeing[BLOCK_ENTRIES];
      int          nxt[BLOCK_ENTRIES], prv[BLOCK_ENTRIES], qlink[BLOCK_ENTRIES];
      int          addr_head;
      int          frame_head[FRAME_SLOTS];
      int          frame_idx;
      bit [31:0]   id_counter;
      bit          started;
      grant_type   pending[$];
      int          mismatches, checked;

      function void clear();
         pool_bytes = 32'h1000_0000;
         min_align  = 1;
         min_split  = 64;
         for (int i = 0; i < BLOCK_ENTRIES; i++) begin
            listed[i] = 0; used[i] = 0; freeing[i] = 0;
            nxt[i] = NIL; prv[i] = NIL; qlink[i] = NIL;
         end
         for (int f = 0; f < FRAME_SLOTS; f++) frame_head[f] = NIL;
         addr_head  = NIL;
         frame_idx  = 0;
         id_counter = 0;
         started    = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] value);
         case (idx)
            REG_POOL_SIZE: pool_bytes = value;
            REG_MIN_ALIGN: min_align  = value[16:0];
            REG_MIN_BLOCK: min_split  = value;
            default: ;
         endcase
      endfunction

      function int take_spare();
         for (int i = 0; i < BLOCK_ENTRIES; i++) begin
            if (!listed[i]) begin
               listed[i] = 1; used[i] = 0; freeing[i] = 0; qlink[i] = NIL;
               blk_id[i] = id_counter;
               id_counter++;
               return i;
            end
         end
         return NIL;
      endfunction

      function void unlink(int e);
         int p, n;
         p = prv[e];
         n = nxt[e];
         if (p != NIL) nxt[p] = n; else addr_head = n;
         if (n != NIL) prv[n] = p;
         listed[e] = 0; used[e] = 0; freeing[e] = 0;
      endfunction

      function void allocate(bit [31:0] size, bit [31:0] ralign, ref grant_type g);
         longint unsigned align, pad, need, bsize, off, aligned, p;
         int cur, s, e, steps;
         pad = 0; need = 0;
         if (!started) begin
            e = take_spare();
            if (e == NIL) begin g.status = STAT_NO_FIT; return; end
            blk_off[e] = 0; blk_len[e] = pool_bytes;
            prv[e] = NIL; nxt[e] = NIL;
            addr_head = e;
            started = 1;
         end
         align = (ralign > {15'd0, min_align}) ? ralign : min_align;
         if (align == 0) align = 1;
         // Only the top set bit of a non-power-of-two alignment counts.
         p = 1;
         while ((p << 1) <= align && p < (64'd1 << 40)) p <<= 1;
         align = p;
         cur = addr_head;
         for (steps = 0; cur != NIL && steps < BLOCK_ENTRIES; steps++) begin
            if (!used[cur]) begin
               off = blk_off[cur];
               aligned = (off + align - 1) & ~(align - 1);
               pad = aligned - off;
               need = size + pad;
               if (blk_len[cur] >= need) break;
            end
            cur = nxt[cur];
         end
         if (cur == NIL || steps >= BLOCK_ENTRIES) begin g.status = STAT_NO_FIT; return; end
         used[cur] = 1;
         g.status = STAT_OK;
         g.handle = blk_id[cur];
         g.offset = 32'(blk_off[cur] + pad);
         bsize = 1;
         while (bsize < need && bsize < (64'd1 << 40)) bsize <<= 1;
         if (blk_len[cur] <= bsize) return;
         if (blk_len[cur] - bsize < min_split) return;
         s = take_spare();
         if (s == NIL) return;
         blk_len[s] = 32'(blk_len[cur] - bsize);
         blk_off[s] = 32'(blk_off[cur] + bsize);
         nxt[s] = nxt[cur];
         prv[s] = cur;
         if (nxt[cur] != NIL) prv[nxt[cur]] = s;
         nxt[cur] = s;
         blk_len[cur] = 32'(bsize);
      endfunction

      function logic [1:0] release_handle(bit [31:0] handle);
         int b, pv, c, steps;
         b = addr_head;
         pv = NIL;
         for (steps = 0; b != NIL && steps < BLOCK_ENTRIES; steps++) begin
            if (blk_id[b] == handle) break;
            b = nxt[b];
         end
         if (!started || b == NIL || steps >= BLOCK_ENTRIES) return STAT_UNKNOWN;
         if (!used[b] || freeing[b]) return STAT_NOT_USE;
         freeing[b] = 1;
         // The frame queue is kept sorted by offset.
         c = frame_head[frame_idx];
         for (steps = 0; c != NIL && steps < BLOCK_ENTRIES; steps++) begin
            if (blk_off[c] >= blk_off[b]) break;
            pv = c;
            c = qlink[c];
         end
         qlink[b] = c;
         if (pv != NIL) qlink[pv] = b; else frame_head[frame_idx] = b;
         return STAT_OK;
      endfunction

      function void next_frame();
         int t, p, n;
         frame_idx = (frame_idx + 1) % FRAME_SLOTS;
         for (int k = 0; k < BLOCK_ENTRIES; k++) begin
            t = frame_head[frame_idx];
            if (t == NIL) break;
            frame_head[frame_idx] = qlink[t];
            qlink[t] = NIL;
            p = prv[t];
            if (p != NIL && !used[p]) begin
               blk_len[t] = blk_len[t] + blk_len[p];
               blk_off[t] = blk_off[p];
               unlink(p);
            end
            n = nxt[t];
            if (n != NIL && !used[n]) begin
               blk_len[n] = blk_len[n] + blk_len[t];
               blk_off[n] = blk_off[t];
               unlink(t);
            end else begin
               used[t] = 0;
               freeing[t] = 0;
            end
         end
      endfunction

      // Called on each request transfer; returns the grant it will produce.
      function grant_type note_request(logic [1:0] mode, logic [31:0] size,
                                       logic [31:0] ralign, logic [31:0] handle);
         grant_type g;
         g.status = STAT_OK; g.handle = 0; g.offset = 0;
         case (mode)
            MODE_ALLOC: begin
               allocate(size, ralign, g);
               if (g.status != STAT_OK) begin g.handle = 0; g.offset = 0; end
            end
            MODE_FREE:  g.status = release_handle(handle);
            MODE_FRAME: next_frame();
            default: ;
         endcase
         pending.push_back(g);
         return g;
      endfunction

      function void check_result(logic [71:0] data);
         grant_type e;
         checked++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("ERROR: result %h arrived with none expected", data);
            return;
         end
         e = pending.pop_front();
         if (data[1:0] !== e.status || data[33:2] !== e.handle || data[65:34] !== e.offset) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d: expected status %0d handle %h offset %h, got status %0d handle %h offset %h",
                        checked, e.status, e.handle, e.offset, data[1:0], data[33:2], data[65:34]);
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [1:0]  req_tuser = MODE_FRAME;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = REG_POOL_SIZE;
   logic [31:0] csr_wdata = '0;

   alloc_scoreboard_type grants = new();
   bit [31:0] live_handles[$];
   bit        steady = 0;       // when set, neither side idles
   int        hold_request = 0; // receiver back-pressure burst length, 0 when none
   int        quiet_cycles = 0;
   int        n_alloc = 0, n_free = 0, n_frame = 0, n_csr = 0;

   first_fit_suballocator_deferred_free_top DUT (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Result side: ready idles at random and honors one long hold-off burst.
   initial begin
      int held;
      forever begin
         @(negedge clock);
         if (reset) rsp_tready <= 0;
         else if (hold_request > 0) begin
            rsp_tready <= 0;
            held = 1;
            while (held < hold_request) begin
               @(negedge clock);
               held++;
            end
            hold_request = 0;
         end else rsp_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 27);
      end
   end

   // Every result transfer is checked against the oldest expected grant.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) grants.check_result(rsp_tdata);
   end

   // Watchdog: too long with no transfer on any channel means the block hung.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, grants.pending.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Present one request and hold it until the transfer; then maybe idle.
   task automatic send_request(logic [1:0] mode, logic [31:0] size,
                               logic [31:0] ralign, logic [31:0] handle);
      grant_type g;
      @(negedge clock);
      req_tvalid <= 1;
      req_tuser  <= mode;
      req_tdata  <= {handle, ralign, size};
      do @(posedge clock); while (!req_tready);
      g = grants.note_request(mode, size, ralign, handle);
      if (mode == MODE_ALLOC && g.status == STAT_OK) live_handles.push_back(g.handle);
      case (mode)
         MODE_ALLOC: n_alloc++;
         MODE_FREE:  n_free++;
         default:    n_frame++;
      endcase
      if (!steady && $urandom_range(0, 99) < 27) begin
         @(negedge clock);
         req_tvalid <= 0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
      end
   endtask

   // The last request has already been taken, so the input goes quiet first.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 0;
      while (grants.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register writes only happen with nothing in flight.
   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      drain();
      @(negedge clock);
      req_tvalid <= 0;
      csr_valid  <= 1;
      csr_index  <= idx;
      csr_wdata  <= value;
      do @(posedge clock); while (!csr_ready);
      grants.write_reg(idx, value);
      n_csr++;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 2000);
      if (r < 92) return $urandom_range(0, 1 << 20);
      return $urandom;
   endfunction

   function automatic logic [31:0] pick_alignment();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return 32'd1 << $urandom_range(0, 12);
      if (r < 90) return 32'd1 << $urandom_range(0, 31);
      return $urandom | 32'd1;   // not a power of two: only the top bit counts
   endfunction

   task automatic random_traffic(int count);
      int r, k;
      bit [31:0] h;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         if (r < 45) send_request(MODE_ALLOC, pick_size(), pick_alignment(), $urandom);
         else if (r < 80) begin
            if (live_handles.size() != 0 && $urandom_range(0, 99) < 80) begin
               k = $urandom_range(0, live_handles.size() - 1);
               h = live_handles[k];
               // Leaving the handle in the list now and then gives double frees.
               if ($urandom_range(0, 9) != 0) live_handles.delete(k);
            end else h = $urandom;
            send_request(MODE_FREE, $urandom, $urandom, h);
         end else send_request(MODE_FRAME, $urandom, $urandom, $urandom);
      end
   endtask

   initial begin
      grants.clear();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Largest pool, no alignment floor, default split threshold.
      write_csr(REG_POOL_SIZE, 32'hFFFF_FFFF);
      write_csr(REG_MIN_ALIGN, 32'd1);
      write_csr(REG_MIN_BLOCK, 32'd64);

      // Directed: requests before the pool exists, then the special cases.
      send_request(MODE_FREE,  0, 1, 32'd0);          // unknown handle before start
      send_request(MODE_FRAME, 0, 1, 0);              // frame before start
      send_request(MODE_ALLOC, 32'd0, 32'd1, 0);      // zero need, handle zero
      send_request(MODE_ALLOC, 32'hFFFF_FFFF, 32'd1, 0);
      send_request(MODE_ALLOC, 32'd100, 32'h8000_0000, 0);
      send_request(MODE_ALLOC, 32'd33, 32'd3, 0);     // non-power alignment
      send_request(MODE_ALLOC, 32'd4096, 32'd64, 0);
      send_request(MODE_FREE,  0, 1, 32'd0);
      send_request(MODE_FREE,  0, 1, 32'd0);          // already freeing
      send_request(MODE_FREE,  0, 1, 32'hFFFF_FFFF);  // unknown handle
      send_request(MODE_FREE,  0, 1, 32'd1);          // block in use, queued for release
      send_request(MODE_FREE,  0, 1, 32'd2);
      send_request(MODE_FRAME, 0, 1, 0);
      send_request(MODE_FRAME, 0, 1, 0);
      send_request(MODE_FRAME, 0, 1, 0);              // ring wraps, blocks merge
      send_request(MODE_ALLOC, 32'h7FFF_FFFF, 32'd1, 0);
      send_request(MODE_ALLOC, 32'd64, 32'd1, 32'hFFFF_FFFF);
      send_request(MODE_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h5555_AAAA);

      random_traffic(150);

      // Sender waits for every result, then the result side holds off
      // while requests keep coming until the input stalls.
      drain();
      hold_request = HOLD_CYCLES;
      random_traffic(40);

      // Large alignment floor, and a pool size write that no longer matters.
      write_csr(REG_MIN_ALIGN, 32'd65536);
      write_csr(REG_POOL_SIZE, 32'd64);
      random_traffic(170);

      // Smallest split threshold, with a stretch where nothing idles.
      write_csr(REG_MIN_ALIGN, 32'd1);
      write_csr(REG_MIN_BLOCK, 32'd1);
      steady = 1;
      random_traffic(200);
      steady = 0;

      // No remainder is ever large enough to split.
      write_csr(REG_MIN_BLOCK, 32'hFFFF_FFFF);
      write_csr(REG_MIN_ALIGN, 32'd16);
      random_traffic(180);

      write_csr(REG_MIN_BLOCK, 32'd4096);
      random_traffic(190);

      @(negedge clock);
      req_tvalid <= 0;
      drain();

      $display("Covered %0d allocates, %0d frees and %0d frame starts over %0d register writes;",
               n_alloc, n_free, n_frame, n_csr);
      $display("%0d results checked, %0d mismatches.", grants.checked, grants.mismatches);
      if (grants.mismatches == 0 && grants.pending.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
